>>> rtl/core/isr_pkg.sv
// Shared types and constants for the integer square root block.
package isr_pkg;

  // Default operand width and fixed result width
  localparam int DATA_WIDTH_DEF = 64;
  localparam int ROOT_W         = 32;

  // Sequencer controls toward the datapath and output register
  typedef struct packed {
    logic load;      // capture a new operand
    logic step;      // resolve one root bit
    logic out_load;  // write the output register
    logic sel_nxt;   // take the result from this cycle's step
  } ctrl_t;

endpackage

>>> rtl/core/isr_seq.sv
// Sequencer: walks the shared subtract unit through one root bit per cycle.
module isr_seq #(
  parameter int STEPS = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          out_free,
  output logic          busy,
  output isr_pkg::ctrl_t ctrl
);

  localparam int CW = (STEPS > 1) ? $clog2(STEPS) : 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_HOLD = 2'd2;

  logic [1:0]    state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  // Next state and control decode
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    ctrl      = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          ctrl.load = 1'b1;
          cnt_nxt   = '0;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        ctrl.step = 1'b1;
        if (cnt_r == CW'(STEPS - 1)) begin
          if (out_free) begin
            ctrl.out_load = 1'b1;
            ctrl.sel_nxt  = 1'b1;
            state_nxt     = ST_IDLE;
          end else begin
            state_nxt = ST_HOLD;
          end
        end else begin
          cnt_nxt = cnt_r + CW'(1);
        end
      end
      ST_HOLD: begin
        // final root sits in the datapath until the output register frees up
        if (out_free) begin
          ctrl.out_load = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

endmodule

>>> rtl/core/isr_unit.sv
// Datapath: remainder, partial root and bit registers around one subtractor.
module isr_unit #(
  parameter int DATA_WIDTH = 64
) (
  input  logic                  clk,
  input  isr_pkg::ctrl_t        ctrl,
  input  logic [DATA_WIDTH-1:0] operand,
  output logic [DATA_WIDTH-1:0] res_cur,
  output logic [DATA_WIDTH-1:0] res_nxt
);

  // Highest even bit position that the root bit starts from
  localparam int TOP = ((DATA_WIDTH - 2) / 2) * 2;
  localparam logic [DATA_WIDTH-1:0] BIT_INIT = {{(DATA_WIDTH-1){1'b0}}, 1'b1} << TOP;

  logic [DATA_WIDTH-1:0] v_r, res_r, bit_r;
  logic [DATA_WIDTH-1:0] trial;
  logic [DATA_WIDTH:0]   diff;
  logic                  ge;

  // Shared unit: trial subtract, borrow says whether the bit fits
  always_comb begin
    trial   = res_r + bit_r;
    diff    = {1'b0, v_r} - {1'b0, trial};
    ge      = !diff[DATA_WIDTH];
    res_nxt = ge ? ((res_r >> 1) + bit_r) : (res_r >> 1);
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      // negative operand runs on zero, which yields a zero root
      v_r   <= operand[DATA_WIDTH-1] ? '0 : operand;
      res_r <= '0;
      bit_r <= BIT_INIT;
    end else if (ctrl.step) begin
      if (ge) begin
        v_r <= diff[DATA_WIDTH-1:0];
      end
      res_r <= res_nxt;
      bit_r <= bit_r >> 2;
    end
  end

  assign res_cur = res_r;

endmodule

>>> rtl/core/integer_square_root.sv
// The sequencer runs STEPS = (DATA_WIDTH-2)/2+1 root steps (32 at 64 bits) per operand; the single
// subtractor settles one root bit per cycle, and the input stays stalled while a root is being
// worked out. A finished root moves to the output register once that is free, and the next
// operand is taken while it waits there.
// Reset: rst_n is synchronous, active low; it idles the sequencer and drops out_valid.
module integer_square_root #(
  parameter int DATA_WIDTH = isr_pkg::DATA_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] in_operand,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [isr_pkg::ROOT_W-1:0] out_root
);

  localparam int STEPS = ((DATA_WIDTH - 2) / 2) + 1;

  isr_pkg::ctrl_t        ctrl;
  logic                  busy;
  logic                  out_free;
  logic [DATA_WIDTH-1:0] res_cur, res_nxt;
  logic                  out_valid_r;
  logic [isr_pkg::ROOT_W-1:0] out_root_r;

  assign out_free = !out_valid_r || !out_stall;

  isr_seq #(
    .STEPS (STEPS)
  ) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .out_free (out_free),
    .busy     (busy),
    .ctrl     (ctrl)
  );

  isr_unit #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_unit (
    .clk     (clk),
    .ctrl    (ctrl),
    .operand (in_operand[DATA_WIDTH-1:0]),
    .res_cur (res_cur),
    .res_nxt (res_nxt)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_load) begin
      out_root_r <= isr_pkg::ROOT_W'(ctrl.sel_nxt ? res_nxt : res_cur);
    end
  end

  assign in_stall  = busy;
  assign out_valid = out_valid_r;
  assign out_root  = out_root_r;

`ifndef SYNTHESIS
  // accepted operand keeps the input stalled while the root is worked out
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled after accepting an operand");

  // a result never overwrites one that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.out_load |-> out_free)
    else $error("output register overwritten while stalled");

  // a loaded result shows up as valid on the next cycle
  a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.out_load |=> out_valid)
    else $error("loaded result not presented");

  // the datapath only steps while the block is busy
  a_step_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.step |-> (in_stall && !ctrl.load))
    else $error("datapath stepped while idle");
`endif

endmodule
